// File: rtl/core/sdft_pkg.sv
package sdft_pkg;

  localparam int NUM_CH         = 3;
  localparam int SAMPLE_W       = 10;
  localparam int THR_W          = 15;
  localparam int ACC_W          = 16;
  localparam int HIT_W          = 8;
  localparam int WINDOW_LEN_DEF = 32;
  localparam int FRAME_LEN_DEF  = 256;
  localparam int CFG_IDX_W      = 2;

  localparam logic [THR_W-1:0] THR_RST_CH1 = THR_W'(2100);
  localparam logic [THR_W-1:0] THR_RST_CH2 = THR_W'(1650);
  localparam logic [THR_W-1:0] THR_RST_CH3 = THR_W'(1600);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_CH1 = 2'd0,
    CFG_THR_CH2 = 2'd1,
    CFG_THR_CH3 = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
  } in_t;

  typedef struct packed {
    logic             detect_ch1;
    logic             detect_ch2;
    logic             detect_ch3;
    logic             seen_ch1;
    logic             seen_ch2;
    logic             seen_ch3;
    logic [HIT_W-1:0] first_hit_ch1;
    logic [HIT_W-1:0] first_hit_ch2;
    logic [HIT_W-1:0] first_hit_ch3;
    logic             frame_end;
  } out_t;

  typedef struct packed {
    logic             accept;
    logic             clear;
    logic             full;
    logic             advance;
    logic             s1_close;
    logic [HIT_W-1:0] s1_idx;
  } seq_ctl_t;

  typedef struct packed {
    logic             det;
    logic             seen;
    logic [HIT_W-1:0] first_hit;
  } lane_res_t;

endpackage

// File: rtl/core/sdft_seq.sv
module sdft_seq #(
  parameter int WINDOW_LEN = sdft_pkg::WINDOW_LEN_DEF,
  parameter int FRAME_LEN  = sdft_pkg::FRAME_LEN_DEF,
  localparam int PtrW = $clog2(WINDOW_LEN)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output sdft_pkg::seq_ctl_t ctl_o,
  output logic [PtrW-1:0]    wr_addr_o,
  output logic [PtrW-1:0]    rd_addr_o
);

  localparam int CntW = (FRAME_LEN > 256) ? $clog2(FRAME_LEN) : sdft_pkg::HIT_W;

  logic [CntW-1:0]            idx_q, idx_d;
  logic [PtrW-1:0]            wptr_q, wptr_d;
  logic                       full_q, full_d;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_close_q;
  logic [sdft_pkg::HIT_W-1:0] s1_idx_q;
  logic                       out_valid_q, out_valid_d;
  logic                       advance, accept, close_now, wrap;

  assign advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;
  assign close_now  = (idx_q == CntW'(FRAME_LEN - 1));
  assign wrap       = (wptr_q == PtrW'(WINDOW_LEN - 1));

  always_comb begin
    idx_d  = idx_q;
    wptr_d = wptr_q;
    full_d = full_q;
    if (accept) begin
      if (close_now) begin
        idx_d  = '0;
        wptr_d = '0;
        full_d = 1'b0;
      end else begin
        idx_d  = idx_q + CntW'(1);
        wptr_d = wrap ? '0 : wptr_q + PtrW'(1);
        full_d = full_q | wrap;
      end
    end
  end

  assign s1_valid_d  = accept | (s1_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      wptr_q      <= '0;
      full_q      <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      s1_close_q  <= 1'b0;
      s1_idx_q    <= '0;
    end else begin
      idx_q       <= idx_d;
      wptr_q      <= wptr_d;
      full_q      <= full_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        s1_close_q <= close_now;
        s1_idx_q   <= idx_q[sdft_pkg::HIT_W-1:0];
      end
    end
  end

  assign ctl_o.accept   = accept;
  assign ctl_o.clear    = accept & close_now;
  assign ctl_o.full     = full_q;
  assign ctl_o.advance  = advance;
  assign ctl_o.s1_close = s1_close_q;
  assign ctl_o.s1_idx   = s1_idx_q;
  assign wr_addr_o      = wptr_q;
  assign rd_addr_o      = wptr_d;
  assign out_valid_o    = out_valid_q;

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.clear |=> (idx_q == '0) && (wptr_q == '0) && !full_q)
    else $error("frame close did not clear sequencer state");

endmodule

// File: rtl/core/sdft_lane.sv
module sdft_lane #(
  parameter int WINDOW_LEN = sdft_pkg::WINDOW_LEN_DEF,
  localparam int PtrW = $clog2(WINDOW_LEN)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdft_pkg::seq_ctl_t            ctl_i,
  input  logic [PtrW-1:0]               wr_addr_i,
  input  logic [PtrW-1:0]               rd_addr_i,
  input  logic [sdft_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [sdft_pkg::THR_W-1:0]    threshold_i,
  output sdft_pkg::lane_res_t           res_o
);

  localparam int AccW = sdft_pkg::ACC_W;
  localparam int HitW = sdft_pkg::HIT_W;

  logic [sdft_pkg::SAMPLE_W-1:0] mem_q [WINDOW_LEN];
  logic [sdft_pkg::SAMPLE_W-1:0] old_q;
  logic signed [AccW-1:0]        ra_q, rb_q;
  logic signed [AccW-1:0]        re_q, im_q;
  logic                          flag_q;
  logic [HitW-1:0]               time_q;

  logic signed [AccW-1:0] x, old, t1, t2, t3, v, re, im;
  logic [AccW-1:0]        abs_re, abs_im, mag;
  logic                   det, seen;
  logic [HitW-1:0]        first_hit;

  assign x   = AccW'({6'd0, sample_i});
  assign old = ctl_i.full ? AccW'({6'd0, old_q}) : '0;

  assign t1 = ra_q + (ra_q >>> 4) + (ra_q >>> 5) + (ra_q >>> 6)
            + (ra_q >>> 10) + (ra_q >>> 11) + (ra_q >>> 12);
  assign v  = x + t1 - rb_q - old;
  assign t2 = (ra_q >>> 1) + (ra_q >>> 5) + (ra_q >>> 6) + (ra_q >>> 7) + (ra_q >>> 10);
  assign t3 = (ra_q >>> 1) + (ra_q >>> 2) + (ra_q >>> 4) + (ra_q >>> 6)
            + (ra_q >>> 9) + (ra_q >>> 10) + (ra_q >>> 11);
  assign re = v - t2;
  assign im = -t3;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      mem_q[wr_addr_i] <= sample_i;
      old_q            <= mem_q[rd_addr_i];
      re_q             <= re;
      im_q             <= im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q <= '0;
      rb_q <= '0;
    end else if (ctl_i.accept) begin
      if (ctl_i.clear) begin
        ra_q <= '0;
        rb_q <= '0;
      end else begin
        ra_q <= v;
        rb_q <= ra_q;
      end
    end
  end

  assign abs_re = re_q[AccW-1] ? AccW'(-re_q) : AccW'(re_q);
  assign abs_im = im_q[AccW-1] ? AccW'(-im_q) : AccW'(im_q);
  assign mag    = abs_re + abs_im;
  assign det    = ~mag[AccW-1] & (mag[AccW-2:0] > threshold_i);
  assign seen   = flag_q | det;
  assign first_hit = (!flag_q && det) ? ctl_i.s1_idx : time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
      time_q <= '0;
    end else if (ctl_i.advance) begin
      if (ctl_i.s1_close) begin
        flag_q <= 1'b0;
        time_q <= '0;
      end else begin
        flag_q <= seen;
        time_q <= first_hit;
      end
    end
  end

  assign res_o.det       = det;
  assign res_o.seen      = seen;
  assign res_o.first_hit = first_hit;

endmodule

// File: rtl/core/sliding_dft_tone_detector.sv
// Three-channel single-bin sliding DFT tone detector. One word carries a 10-bit sample for
// each channel; three identical lanes each run a comb plus two-tap shift-add resonator in
// 16-bit wrapping arithmetic, form |re|+|im| and compare it with that channel's threshold,
// and the output register merges the lanes' detect, seen and first-hit results into one
// result word. A new word is taken every clock unless the output stalls. Each word passes
// the re/im and output registers: the resonator recurrence closes in the accept cycle, the
// magnitude, compare and first-hit latch as the word enters the output register. Each lane
// keeps a WINDOW_LEN-entry delay memory whose read is prefetched one word ahead; a fill
// flag makes unwritten entries read as zero, so no clearing pass is needed after reset or
// at frame close. Every FRAME_LEN words the result carries frame_end, after which index,
// resonators, delay history and hit flags start from zero. The user writes thresholds
// through the cfg port while the block is idle; the block does not enforce it.
module sliding_dft_tone_detector #(
  parameter int WINDOW_LEN = sdft_pkg::WINDOW_LEN_DEF,
  parameter int FRAME_LEN  = sdft_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sdft_pkg::in_t                  in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sdft_pkg::out_t                 out_word_o,
  input  logic                           cfg_we_i,
  input  logic [sdft_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdft_pkg::THR_W-1:0]     cfg_data_i
);

  localparam int PtrW = $clog2(WINDOW_LEN);

  sdft_pkg::seq_ctl_t                                   ctl;
  logic [PtrW-1:0]                                      wr_addr, rd_addr;
  logic [sdft_pkg::NUM_CH-1:0][sdft_pkg::SAMPLE_W-1:0] samples;
  logic [sdft_pkg::NUM_CH-1:0][sdft_pkg::THR_W-1:0]    thr_q;
  sdft_pkg::lane_res_t [sdft_pkg::NUM_CH-1:0]           res;
  sdft_pkg::out_t                                       out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q[0] <= sdft_pkg::THR_RST_CH1;
      thr_q[1] <= sdft_pkg::THR_RST_CH2;
      thr_q[2] <= sdft_pkg::THR_RST_CH3;
    end else if (cfg_we_i) begin
      case (sdft_pkg::cfg_reg_e'(cfg_idx_i))
        sdft_pkg::CFG_THR_CH1: thr_q[0] <= cfg_data_i;
        sdft_pkg::CFG_THR_CH2: thr_q[1] <= cfg_data_i;
        sdft_pkg::CFG_THR_CH3: thr_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdft_seq #(
    .WINDOW_LEN(WINDOW_LEN),
    .FRAME_LEN (FRAME_LEN)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .ctl_o      (ctl),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  assign samples[0] = in_word_i.sample_ch1;
  assign samples[1] = in_word_i.sample_ch2;
  assign samples[2] = in_word_i.sample_ch3;

  for (genvar c = 0; c < sdft_pkg::NUM_CH; c++) begin : g_lane
    sdft_lane #(
      .WINDOW_LEN(WINDOW_LEN)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .wr_addr_i  (wr_addr),
      .rd_addr_i  (rd_addr),
      .sample_i   (samples[c]),
      .threshold_i(thr_q[c]),
      .res_o      (res[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctl.advance) begin
      out_q.detect_ch1    <= res[0].det;
      out_q.detect_ch2    <= res[1].det;
      out_q.detect_ch3    <= res[2].det;
      out_q.seen_ch1      <= res[0].seen;
      out_q.seen_ch2      <= res[1].seen;
      out_q.seen_ch3      <= res[2].seen;
      out_q.first_hit_ch1 <= res[0].first_hit;
      out_q.first_hit_ch2 <= res[1].first_hit;
      out_q.first_hit_ch3 <= res[2].first_hit;
      out_q.frame_end     <= ctl.s1_close;
    end
  end

  assign out_word_o = out_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output register could drain");

  a_detect_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.detect_ch1 |-> out_word_o.seen_ch1)
    else $error("channel one detect without seen");

  a_unseen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.seen_ch2 |-> out_word_o.first_hit_ch2 == '0)
    else $error("channel two first hit set while unseen");

endmodule

// File: dv/sliding_dft_tone_detector_test.sv
module sliding_dft_tone_detector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH    = sdft_pkg::NUM_CH;
  localparam int SAMPLE_W  = sdft_pkg::SAMPLE_W;
  localparam int THR_W     = sdft_pkg::THR_W;
  localparam int ACC_W     = sdft_pkg::ACC_W;
  localparam int HIT_W     = sdft_pkg::HIT_W;
  localparam int CFG_IDX_W = sdft_pkg::CFG_IDX_W;

  typedef sdft_pkg::in_t  in_t;
  typedef sdft_pkg::out_t out_t;

  localparam int WIN = sdft_pkg::WINDOW_LEN_DEF;
  localparam int FRAME = sdft_pkg::FRAME_LEN_DEF;
  localparam real TWO_PI = 6.283185307179586;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam sdft_pkg::cfg_reg_e THR_REG [NUM_CH] =
    '{sdft_pkg::CFG_THR_CH1, sdft_pkg::CFG_THR_CH2, sdft_pkg::CFG_THR_CH3};
  localparam out_t NO_HIT = '0;

  typedef enum int {BURST_TONE, BURST_SQUARE, BURST_NOISE, BURST_RAIL, BURST_FLAT} burst_e;

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t want;
  } stim_row_t;

  localparam int NUM_ROWS = 20;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    {10'd0,    10'd0,    10'd0,    1'b1, NO_HIT},
    {10'd1023, 10'd1023, 10'd1023, 1'b1, NO_HIT},
    {10'd0,    10'd1023, 10'd512,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd511,  1'b0, NO_HIT},
    {10'h155,  10'h2aa,  10'd1,    1'b0, NO_HIT},
    {10'h2aa,  10'h155,  10'd1022, 1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd1023, 10'd0,    10'd767,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT},
    {10'd0,    10'd1023, 10'd256,  1'b0, NO_HIT}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_t                  in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_word_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [THR_W-1:0]     cfg_data_i = '0;

  logic [SAMPLE_W-1:0] hist [NUM_CH][WIN];
  int                  hist_ptr;
  logic [ACC_W-1:0]    res_cur [NUM_CH];
  logic [ACC_W-1:0]    res_prev [NUM_CH];
  int                  frame_idx;
  logic                hit_seen [NUM_CH];
  logic [HIT_W-1:0]    hit_at [NUM_CH];
  logic [THR_W-1:0]    thr [NUM_CH];

  out_t tone_results_due [$];
  int   mismatches = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;

  sliding_dft_tone_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ACC_W-1:0] asr(input logic [ACC_W-1:0] v, input int k);
    return ACC_W'($signed(v) >>> k);
  endfunction

  function automatic void clear_frame();
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < WIN; i++) hist[c][i] = '0;
      res_cur[c] = '0;
      res_prev[c] = '0;
      hit_seen[c] = 1'b0;
      hit_at[c] = '0;
    end
    hist_ptr = 0;
    frame_idx = 0;
  endfunction

  function automatic out_t tone_step(input in_t w);
    logic [SAMPLE_W-1:0] x [NUM_CH];
    logic [ACC_W-1:0]    a, old, t, v, re, im, mag;
    logic [NUM_CH-1:0]   det, seen;
    logic [HIT_W-1:0]    at [NUM_CH];
    out_t                r;
    x[0] = w.sample_ch1;
    x[1] = w.sample_ch2;
    x[2] = w.sample_ch3;
    for (int c = 0; c < NUM_CH; c++) begin
      a = res_cur[c];
      old = {{(ACC_W-SAMPLE_W){1'b0}}, hist[c][hist_ptr]};
      hist[c][hist_ptr] = x[c];
      t = a + asr(a, 4) + asr(a, 5) + asr(a, 6) + asr(a, 10) + asr(a, 11) + asr(a, 12);
      v = {{(ACC_W-SAMPLE_W){1'b0}}, x[c]} + t - res_prev[c] - old;
      t = asr(a, 1) + asr(a, 5) + asr(a, 6) + asr(a, 7) + asr(a, 10);
      re = v - t;
      t = asr(a, 1) + asr(a, 2) + asr(a, 4) + asr(a, 6) + asr(a, 9) + asr(a, 10)
          + asr(a, 11);
      im = ACC_W'(0) - t;
      mag = (re[ACC_W-1] ? ACC_W'(0) - re : re) + (im[ACC_W-1] ? ACC_W'(0) - im : im);
      det[c] = $signed(mag) > $signed({1'b0, thr[c]});
      if (det[c]) begin
        if (!hit_seen[c]) hit_at[c] = HIT_W'(frame_idx);
        hit_seen[c] = 1'b1;
      end
      res_prev[c] = a;
      res_cur[c] = v;
      seen[c] = hit_seen[c];
      at[c] = hit_at[c];
    end
    hist_ptr = (hist_ptr == WIN - 1) ? 0 : hist_ptr + 1;
    frame_idx++;
    r.detect_ch1 = det[0];
    r.detect_ch2 = det[1];
    r.detect_ch3 = det[2];
    r.seen_ch1 = seen[0];
    r.seen_ch2 = seen[1];
    r.seen_ch3 = seen[2];
    r.first_hit_ch1 = at[0];
    r.first_hit_ch2 = at[1];
    r.first_hit_ch3 = at[2];
    r.frame_end = frame_idx >= FRAME;
    if (r.frame_end) clear_frame();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (tone_results_due.size() == 0) begin
      report_mismatch("result word with none outstanding", longint'(got), longint'(0));
      return;
    end
    want = tone_results_due.pop_front();
    if (got.detect_ch1 !== want.detect_ch1)
      report_mismatch("detect_ch1", longint'(got.detect_ch1), longint'(want.detect_ch1));
    if (got.detect_ch2 !== want.detect_ch2)
      report_mismatch("detect_ch2", longint'(got.detect_ch2), longint'(want.detect_ch2));
    if (got.detect_ch3 !== want.detect_ch3)
      report_mismatch("detect_ch3", longint'(got.detect_ch3), longint'(want.detect_ch3));
    if (got.seen_ch1 !== want.seen_ch1)
      report_mismatch("seen_ch1", longint'(got.seen_ch1), longint'(want.seen_ch1));
    if (got.seen_ch2 !== want.seen_ch2)
      report_mismatch("seen_ch2", longint'(got.seen_ch2), longint'(want.seen_ch2));
    if (got.seen_ch3 !== want.seen_ch3)
      report_mismatch("seen_ch3", longint'(got.seen_ch3), longint'(want.seen_ch3));
    if (got.first_hit_ch1 !== want.first_hit_ch1)
      report_mismatch("first_hit_ch1", longint'(got.first_hit_ch1),
                      longint'(want.first_hit_ch1));
    if (got.first_hit_ch2 !== want.first_hit_ch2)
      report_mismatch("first_hit_ch2", longint'(got.first_hit_ch2),
                      longint'(want.first_hit_ch2));
    if (got.first_hit_ch3 !== want.first_hit_ch3)
      report_mismatch("first_hit_ch3", longint'(got.first_hit_ch3),
                      longint'(want.first_hit_ch3));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", longint'(got.frame_end), longint'(want.frame_end));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_word_o);
    if (steady) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_word(input in_t w, input logic typed = 1'b0, input out_t want = '0);
    out_t predicted;
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = tone_step(w);
    tone_results_due.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tone_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [THR_W-1:0] t1, t2, t3);
    logic [THR_W-1:0] vals [NUM_CH];
    vals = '{t1, t2, t3};
    drain_results();
    for (int c = 0; c < NUM_CH; c++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= THR_REG[c];
      cfg_data_i <= vals[c];
      @(posedge clk_i);
      thr[c] = vals[c];
    end
    // unmapped index: must leave every threshold alone
    cfg_idx_i <= CFG_IDX_UNUSED;
    cfg_data_i <= THR_W'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic play_burst(input burst_e kind, input int len);
    int                  amp [NUM_CH];
    int                  ofs [NUM_CH];
    int                  ph [NUM_CH];
    int                  bin, v;
    logic [SAMPLE_W-1:0] hi [NUM_CH];
    logic [SAMPLE_W-1:0] lo [NUM_CH];
    logic [SAMPLE_W-1:0] s [NUM_CH];
    bin = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
    for (int c = 0; c < NUM_CH; c++) begin
      amp[c] = $urandom_range(0, 511);
      ofs[c] = $urandom_range(amp[c], 1023 - amp[c]);
      ph[c] = $urandom_range(0, WIN - 1);
      hi[c] = SAMPLE_W'($urandom_range(512, 1023));
      lo[c] = SAMPLE_W'($urandom_range(0, 511));
    end
    for (int n = 0; n < len; n++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        case (kind)
          BURST_TONE: begin
            v = ofs[c] + $rtoi(amp[c] * $cos(TWO_PI * ((bin * n + ph[c]) % WIN) / WIN));
            s[c] = (v < 0) ? '0 : (v > 1023) ? '1 : SAMPLE_W'(v);
          end
          BURST_SQUARE: s[c] = (((bin * n + ph[c]) % WIN) < WIN / 2) ? hi[c] : lo[c];
          BURST_NOISE:  s[c] = SAMPLE_W'($urandom);
          BURST_RAIL:   s[c] = $urandom_range(0, 1) ? '1 : '0;
          default:      s[c] = lo[c] | hi[c];
        endcase
      end
      send_word({s[0], s[1], s[2]});
    end
  endtask

  task automatic run_phase(input int count);
    int     left, len, r;
    burst_e kind;
    left = count;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      kind = (r < 45) ? BURST_TONE : (r < 65) ? BURST_SQUARE : (r < 80) ? BURST_NOISE :
             (r < 90) ? BURST_RAIL : BURST_FLAT;
      len = $urandom_range(8, 64);
      if (len > left) len = left;
      play_burst(kind, len);
      left -= len;
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] mix [NUM_CH];
    clear_frame();
    thr = '{sdft_pkg::THR_RST_CH1, sdft_pkg::THR_RST_CH2, sdft_pkg::THR_RST_CH3};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED_ROWS[i])
      send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    run_phase(230);
    load_thresholds('0, '0, '0);
    run_phase(200);
    load_thresholds('1, '1, '1);
    run_phase(150);
    load_thresholds(THR_W'($urandom_range(0, 32767)), THR_W'($urandom_range(0, 32767)),
                    THR_W'($urandom_range(0, 32767)));
    run_phase(200);
    load_thresholds(THR_W'($urandom_range(400, 6000)), THR_W'($urandom_range(400, 6000)),
                    THR_W'($urandom_range(400, 6000)));
    run_phase(350);
    foreach (mix[c]) begin
      case ($urandom_range(0, 3))
        0:       mix[c] = '0;
        1:       mix[c] = '1;
        2:       mix[c] = THR_W'(1);
        default: mix[c] = THR_W'($urandom);
      endcase
    end
    load_thresholds(mix[0], mix[1], mix[2]);
    run_phase(200);
    load_thresholds(THR_W'($urandom_range(400, 6000)), THR_W'($urandom_range(400, 6000)),
                    THR_W'($urandom_range(400, 6000)));
    steady = 1'b1;
    run_phase(300);
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
